// ===== src/npc_pkg.sv =====
// Shared constants, types and helper function of the nearest point search block.
`default_nettype none

package npc_pkg;

  // Field widths that do not depend on any parameter.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned DIST2_W  = 34;
  localparam int unsigned DIST_W   = 17;
  localparam int unsigned FLAGS_W  = 2;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // Query classes.
  localparam logic [CLASS_W-1:0] CLASS_MECH  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_TRANS = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_AUX   = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Bit positions of the class flags of a stored point.
  localparam int unsigned FLAG_MECH  = 0;
  localparam int unsigned FLAG_TRANS = 1;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MUL  = 6'b000100,
    S_CMP  = 6'b001000,
    S_ROOT = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  // True when a point with the given flags belongs to the queried class.
  function automatic logic class_match(input logic [FLAGS_W-1:0] flags,
                                       input logic [CLASS_W-1:0] cls);
    logic match;
    case (cls)
      CLASS_MECH:  match = flags[FLAG_MECH];
      CLASS_TRANS: match = flags[FLAG_TRANS];
      CLASS_AUX:   match = ~flags[FLAG_MECH] & ~flags[FLAG_TRANS];
      default:     match = 1'b0;
    endcase
    return match;
  endfunction

endpackage

`default_nettype wire

// ===== src/npc_req_if.sv =====
// Request channel of the nearest point search block.
`default_nettype none

interface npc_req_if
  import npc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic signed [COORD_BITS-1:0] z_coord;
  logic                         has_mechanics;
  logic                         has_transport;
  logic [CLASS_W-1:0]           query_class;

  modport source (
    output valid, action, x_coord, y_coord, z_coord, has_mechanics, has_transport,
           query_class,
    input  ready
  );

  modport sink (
    input  valid, action, x_coord, y_coord, z_coord, has_mechanics, has_transport,
           query_class,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/npc_rsp_if.sv =====
// Response channel of the nearest point search block.
`default_nettype none

interface npc_rsp_if
  import npc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  point_index;
  logic [DIST2_W-1:0]  distance_squared;
  logic [DIST_W-1:0]   distance;

  modport source (
    output valid, status, point_index, distance_squared, distance,
    input  ready
  );

  modport sink (
    input  valid, status, point_index, distance_squared, distance,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/nearest_point_by_class.sv =====
// Point table with a class-filtered brute-force nearest point search.
//
// Requests arrive on req_i and responses leave on rsp_o, both valid/ready
// channels; every accepted request yields exactly one response. An append
// stores a point at the next free index, a clear empties the table, and a
// query scans the stored points of one class and reports the nearest one.
// An append, clear or unknown request goes straight to the S_OUT state, from
// which its result is loaded into the output register. A query scans the
// stored points: a point of the queried class takes one read on the point
// memory read port, three passes through the single shared multiplier and
// one add-and-compare step, any other point takes the read and one class
// check, and the floor square root then produces one root bit per cycle.
// req_i.ready is high only while no request is being worked on; a request may
// be taken while the previous response still waits in the output register.
// If the receiver stalls, the response is held in that register and the
// block waits before loading the next one. Reset empties the table at once;
// the point memory itself is not cleared and needs no clearing pass.
`default_nettype none

module nearest_point_by_class
  import npc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  npc_req_if.sink   req_i,
  npc_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned SUM_W  = SQ_W + 2;
  localparam int unsigned ROOT_W = SUM_W / 2;

  typedef struct packed {
    logic [FLAGS_W-1:0]           flags;
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } entry_t;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic [1:0]        phase_q, phase_d;
  logic              found_q, found_d;
  logic [SUM_W-1:0]  best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [SUM_W-1:0]  acc_q, acc_d;

  logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic [CLASS_W-1:0]           qcls_q;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [INDEX_W-1:0]  res_index_q, res_index_d;
  logic [DIST2_W-1:0]  res_dist2_q, res_dist2_d;
  logic [DIST_W-1:0]   res_dist_q, res_dist_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [INDEX_W-1:0]  rsp_index_q;
  logic [DIST2_W-1:0]  rsp_dist2_q;
  logic [DIST_W-1:0]   rsp_dist_q;

  entry_t mem_q [MAX_POINTS];
  entry_t rd_q;
  entry_t wr_entry;
  logic   mem_we;
  logic   mem_re;

  logic                         req_fire;
  logic                         load_out;
  logic                         table_full;
  logic signed [COORD_BITS-1:0] op_a, op_b;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [SQ_W-1:0]       prod;
  logic [SUM_W-1:0]             total;
  logic                         root_start;
  logic                         root_done;
  logic [ROOT_W-1:0]            root;

  assign req_fire   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign table_full = (count_q == CNT_W'(MAX_POINTS));
  assign load_out   = (state_q == S_OUT) && (!rsp_valid_q || rsp_o.ready);

  // Shared multiplier: squares one coordinate difference per cycle.
  always_comb begin
    case (phase_q)
      2'd0:    begin op_a = rd_q.x; op_b = qx_q; end
      2'd1:    begin op_a = rd_q.y; op_b = qy_q; end
      default: begin op_a = rd_q.z; op_b = qz_q; end
    endcase
  end

  assign diff  = DIFF_W'(op_a) - DIFF_W'(op_b);
  assign prod  = diff * diff;
  assign total = acc_q + SUM_W'(sq_q);

  // Point memory write for appends.
  assign wr_entry.flags = {req_i.has_transport, req_i.has_mechanics};
  assign wr_entry.z     = req_i.z_coord;
  assign wr_entry.y     = req_i.y_coord;
  assign wr_entry.x     = req_i.x_coord;
  assign mem_we = req_fire && (req_i.action == ACT_APPEND) && !table_full;
  assign mem_re = (state_q == S_READ) && (scan_q != count_q);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    phase_d      = phase_q;
    found_d      = found_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    sq_d         = sq_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_dist2_d  = res_dist2_q;
    res_dist_d   = res_dist_q;
    root_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_status_d = STATUS_OK;
          res_index_d  = '0;
          res_dist2_d  = '0;
          res_dist_d   = '0;
          state_d      = S_OUT;
          case (req_i.action)
            ACT_APPEND: begin
              if (table_full) begin
                res_status_d = STATUS_FULL;
              end else begin
                res_index_d = INDEX_W'(count_q);
                count_d     = count_q + 1'b1;
              end
            end
            ACT_QUERY: begin
              scan_d  = '0;
              found_d = 1'b0;
              state_d = S_READ;
            end
            ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_READ: begin
        phase_d = 2'd0;
        if (scan_q == count_q) begin
          if (found_q) begin
            root_start  = 1'b1;
            res_index_d = INDEX_W'(best_idx_q);
            res_dist2_d = DIST2_W'(best_q);
            state_d     = S_ROOT;
          end else begin
            res_status_d = STATUS_NOT_FOUND;
            state_d      = S_OUT;
          end
        end else begin
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        sq_d    = $unsigned(prod);
        phase_d = phase_q + 1'b1;
        case (phase_q)
          2'd0: begin
            // Points of another class are skipped without any arithmetic.
            if (!class_match(rd_q.flags, qcls_q)) begin
              scan_d  = scan_q + 1'b1;
              state_d = S_READ;
            end
          end
          2'd1: begin
            acc_d = SUM_W'(sq_q);
          end
          default: begin
            acc_d   = total;
            state_d = S_CMP;
          end
        endcase
      end

      S_CMP: begin
        // Strict compare keeps the lowest index on ties.
        if (!found_q || (total < best_q)) begin
          found_d    = 1'b1;
          best_d     = total;
          best_idx_d = scan_q[IDX_W-1:0];
        end
        scan_d  = scan_q + 1'b1;
        state_d = S_READ;
      end

      S_ROOT: begin
        if (root_done) begin
          res_dist_d = DIST_W'(root);
          state_d    = S_OUT;
        end
      end

      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid: loaded from the result, cleared when taken.
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if (load_out) begin
      rsp_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      phase_q     <= '0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      phase_q     <= phase_d;
      found_q     <= found_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    sq_q         <= sq_d;
    acc_q        <= acc_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_dist2_q  <= res_dist2_d;
    res_dist_q   <= res_dist_d;
    if (req_fire && (req_i.action == ACT_QUERY)) begin
      qx_q   <= req_i.x_coord;
      qy_q   <= req_i.y_coord;
      qz_q   <= req_i.z_coord;
      qcls_q <= req_i.query_class;
    end
    if (load_out) begin
      rsp_status_q <= res_status_q;
      rsp_index_q  <= res_index_q;
      rsp_dist2_q  <= res_dist2_q;
      rsp_dist_q   <= res_dist_q;
    end
  end

  // Point memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IDX_W-1:0]] <= wr_entry;
    end
    if (mem_re) begin
      rd_q <= mem_q[scan_q[IDX_W-1:0]];
    end
  end

  npc_isqrt #(
    .VAL_W (SUM_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (best_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_status_q;
  assign rsp_o.point_index      = rsp_index_q;
  assign rsp_o.distance_squared = rsp_dist2_q;
  assign rsp_o.distance         = rsp_dist_q;

endmodule

`default_nettype wire

// ===== src/npc_isqrt.sv =====
// Iterative floor square root, one root bit per cycle.
`default_nettype none

module npc_isqrt
  import npc_pkg::*;
#(
  parameter int unsigned VAL_W = 36
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [VAL_W-1:0]     value_i,
  output logic                      done_o,
  output logic [(VAL_W/2)-1:0]      root_o
);

  localparam int unsigned ROOT_W = VAL_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [VAL_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // Bring down the next two radicand bits and try the next root bit.
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[VAL_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W);
      rad_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[VAL_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire
